>>> design/rgpe_pkg.sv
// rgpe_pkg: shared types, constants and the threshold table builder
// for the tone map pixel encoder; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rgpe_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int CH_W          = 32;
    localparam int GAIN_W        = 32;
    localparam int BYTE_W        = 8;
    localparam int X_W           = CH_W - 1;
    localparam int THR_W         = X_W + 1;
    localparam int PROD_W        = X_W + GAIN_W;
    localparam int NUM_LEVELS    = 1 << BYTE_W;
    localparam int SEARCH_STEPS  = BYTE_W;
    localparam int SEARCH_FIRST  = 3;
    localparam int SEARCH_REGS   = SEARCH_STEPS - 1;
    localparam int OUT_STAGE     = SEARCH_FIRST + SEARCH_REGS;
    localparam int NUM_STAGES    = OUT_STAGE + 1;
    localparam int BIG_W         = 384;
    localparam int SCALE_NUM     = 255999;
    localparam int SCALE_DEN     = 1000;
    localparam int GAMMA_NUM     = 11;
    localparam int GAMMA_DEN     = 5;

    typedef logic [THR_W-1:0] t_thr_table [NUM_LEVELS];

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
        logic [NUM_STAGES-1:0] valid;
    } t_pipe_ctrl;

    function automatic logic [BIG_W-1:0] big_pow(input logic [BIG_W-1:0] base,
                                                 input int n);
        logic [BIG_W-1:0] acc;
        acc = BIG_W'(1);
        for (int i = 0; i < n; i++) begin
            acc = acc * base;
        end
        return acc;
    endfunction

    // smallest exposed value that reaches each output level
    function automatic t_thr_table build_thresholds(input int frac_bits);
        t_thr_table       tbl;
        logic [BIG_W-1:0] num_pow;
        logic [BIG_W-1:0] lvl_pow;
        logic [BIG_W-1:0] lhs;
        logic [BIG_W-1:0] rhs;
        logic [THR_W:0]   lo;
        logic [THR_W:0]   hi;
        logic [THR_W:0]   mid;
        num_pow = big_pow(BIG_W'(SCALE_NUM), GAMMA_NUM);
        tbl[0]  = '0;
        for (int k = 1; k < NUM_LEVELS; k++) begin
            lvl_pow = big_pow(BIG_W'(SCALE_DEN * k), GAMMA_NUM);
            lo = (THR_W + 1)'(1);
            hi = (THR_W + 1)'(1) << X_W;
            for (int it = 0; it < THR_W + 2; it++) begin
                if (lo < hi) begin
                    mid = (lo + hi) >> 1;
                    lhs = lvl_pow * big_pow(BIG_W'(mid) + (BIG_W'(1) << frac_bits),
                                            GAMMA_DEN);
                    rhs = big_pow(BIG_W'(mid), GAMMA_DEN) * num_pow;
                    if (lhs <= rhs) begin
                        hi = mid;
                    end else begin
                        lo = mid + (THR_W + 1)'(1);
                    end
                end
            end
            tbl[k] = lo[THR_W-1:0];
        end
        return tbl;
    endfunction

endpackage

`default_nettype wire

>>> design/rgpe_ctrl.sv
// rgpe_ctrl: per-stage valid bits and stall chain of the pixel pipeline
// depends on rgpe_pkg
`timescale 1ns / 1ps
`default_nettype none

module rgpe_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_out_ready,
    output logic                     o_in_ready,
    output rgpe_pkg::t_pipe_ctrl     o_ctrl
);

    localparam int LAST = rgpe_pkg::NUM_STAGES - 1;

    logic [rgpe_pkg::NUM_STAGES-1:0] r_valid;
    logic [rgpe_pkg::NUM_STAGES-1:0] n_valid;
    logic [rgpe_pkg::NUM_STAGES-1:0] en;

    // a stage loads when empty or when it hands its request on
    always_comb begin
        en[LAST] = !r_valid[LAST] || i_out_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
        n_valid = r_valid;
        for (int k = 0; k <= LAST; k++) begin
            if (en[k]) begin
                n_valid[k] = (k == 0) ? i_in_valid : r_valid[(k == 0) ? 0 : k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_ready   = en[0];
    assign o_ctrl.en    = en;
    assign o_ctrl.valid = r_valid;

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&r_valid))
        else $error("input stalled with a bubble in the pipeline");

    a_ready_moves_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> (&en))
        else $error("stage held while output side is ready");

    a_stalled_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[LAST] && !i_out_ready |=> r_valid[LAST])
        else $error("stalled result dropped");

endmodule

`default_nettype wire

>>> design/rgpe_lane.sv
// rgpe_lane: one color channel: clamp, exposure multiply and saturate,
// then a pipelined binary search of the level thresholds; depends on rgpe_pkg
`timescale 1ns / 1ps
`default_nettype none

module rgpe_lane #(
    parameter int FRACTION_BITS = rgpe_pkg::FRACTION_BITS
) (
    input  wire logic                                 i_clk,
    input  wire rgpe_pkg::t_pipe_ctrl                 i_ctrl,
    input  wire logic        [rgpe_pkg::GAIN_W-1:0]   i_gain,
    input  wire logic signed [rgpe_pkg::CH_W-1:0]     i_raw,
    output logic             [rgpe_pkg::BYTE_W-1:0]   o_byte
);

    localparam int X_W    = rgpe_pkg::X_W;
    localparam int PROD_W = rgpe_pkg::PROD_W;
    localparam int BYTE_W = rgpe_pkg::BYTE_W;
    localparam int STEPS  = rgpe_pkg::SEARCH_STEPS;
    localparam int NREG   = rgpe_pkg::SEARCH_REGS;
    localparam int FIRST  = rgpe_pkg::SEARCH_FIRST;

    localparam rgpe_pkg::t_thr_table THR = rgpe_pkg::build_thresholds(FRACTION_BITS);

    logic [X_W-1:0]    r_v;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] prod_shift;
    logic [X_W-1:0]    n_x;
    logic [X_W-1:0]    r_x;

    logic [X_W-1:0]    r_sx [NREG];
    logic [BYTE_W-1:0] r_lo [NREG];
    logic [X_W-1:0]    step_x    [STEPS];
    logic [BYTE_W-1:0] step_lo   [STEPS];
    logic [BYTE_W-1:0] step_next [STEPS];

    // negative radiance clamps to zero
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[0]) begin
            r_v <= i_raw[rgpe_pkg::CH_W-1] ? '0 : i_raw[X_W-1:0];
        end
        if (i_ctrl.en[1]) begin
            r_prod <= PROD_W'(r_v) * PROD_W'(i_gain);
        end
        if (i_ctrl.en[2]) begin
            r_x <= n_x;
        end
    end

    always_comb begin
        prod_shift = r_prod >> FRACTION_BITS;
        n_x = (|prod_shift[PROD_W-1:X_W]) ? {X_W{1'b1}} : prod_shift[X_W-1:0];
    end

    assign step_x[0]  = r_x;
    assign step_lo[0] = '0;

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        localparam logic [BYTE_W-1:0] PROBE = BYTE_W'(1) << (BYTE_W - 1 - s);
        logic [BYTE_W-1:0] cand;
        assign cand = step_lo[s] | PROBE;
        assign step_next[s] = ({1'b0, step_x[s]} >= THR[cand]) ? cand : step_lo[s];
        if (s > 0) begin : g_feed
            assign step_x[s]  = r_sx[s-1];
            assign step_lo[s] = r_lo[s-1];
        end
        if (s < NREG) begin : g_reg
            always_ff @(posedge i_clk) begin
                if (i_ctrl.en[FIRST+s]) begin
                    r_sx[s] <= step_x[s];
                    r_lo[s] <= step_next[s];
                end
            end
        end
    end

    assign o_byte = step_next[STEPS-1];

endmodule

`default_nettype wire

>>> design/reinhard_gamma_pixel_encoder.sv
// reinhard_gamma_pixel_encoder: top level, gain register, three channel
// lanes and the merged output register; depends on rgpe_pkg, rgpe_ctrl, rgpe_lane
//
// channel  signals                                   direction
// in       i_in_valid  o_in_ready  i_red/green/blue_in   into block
// out      o_out_valid i_out_ready o_red/green/blue_out  out of block
// cfg      i_cfg_valid o_cfg_ready i_cfg_data            into block
//
// one pixel per clock until a stalled output fills every stage; a request passes through the stages in order
// the 11 stages: input, 32x31 multiply, shift and saturate, 7 search stages
// holding 8 threshold compares, then the merged output register
// i_rst_n (synchronous) empties the pipeline and sets the gain to 1.0
// a stalled output holds its request; input keeps flowing until every stage is full
`timescale 1ns / 1ps
`default_nettype none

module reinhard_gamma_pixel_encoder #(
    parameter int FRACTION_BITS = rgpe_pkg::FRACTION_BITS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic signed [rgpe_pkg::CH_W-1:0]     i_red_in,
    input  wire logic signed [rgpe_pkg::CH_W-1:0]     i_green_in,
    input  wire logic signed [rgpe_pkg::CH_W-1:0]     i_blue_in,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic             [rgpe_pkg::BYTE_W-1:0]   o_red_out,
    output logic             [rgpe_pkg::BYTE_W-1:0]   o_green_out,
    output logic             [rgpe_pkg::BYTE_W-1:0]   o_blue_out,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic        [rgpe_pkg::GAIN_W-1:0]   i_cfg_data
);

    localparam int BYTE_W = rgpe_pkg::BYTE_W;
    localparam int OUT    = rgpe_pkg::OUT_STAGE;
    localparam logic [rgpe_pkg::GAIN_W-1:0] GAIN_ONE =
        rgpe_pkg::GAIN_W'(1) << FRACTION_BITS;

    rgpe_pkg::t_pipe_ctrl          ctrl;
    logic [rgpe_pkg::GAIN_W-1:0]   r_gain;
    logic [BYTE_W-1:0]             red_byte;
    logic [BYTE_W-1:0]             green_byte;
    logic [BYTE_W-1:0]             blue_byte;
    logic [BYTE_W-1:0]             r_red;
    logic [BYTE_W-1:0]             r_green;
    logic [BYTE_W-1:0]             r_blue;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_ONE;
        end else if (i_cfg_valid) begin
            r_gain <= i_cfg_data;
        end
    end

    rgpe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_ctrl      (ctrl)
    );

    rgpe_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_red (
        .i_clk  (i_clk),
        .i_ctrl (ctrl),
        .i_gain (r_gain),
        .i_raw  (i_red_in),
        .o_byte (red_byte)
    );

    rgpe_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_green (
        .i_clk  (i_clk),
        .i_ctrl (ctrl),
        .i_gain (r_gain),
        .i_raw  (i_green_in),
        .o_byte (green_byte)
    );

    rgpe_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_blue (
        .i_clk  (i_clk),
        .i_ctrl (ctrl),
        .i_gain (r_gain),
        .i_raw  (i_blue_in),
        .o_byte (blue_byte)
    );

    // merged pixel
    always_ff @(posedge i_clk) begin
        if (ctrl.en[OUT]) begin
            r_red   <= red_byte;
            r_green <= green_byte;
            r_blue  <= blue_byte;
        end
    end

    assign o_out_valid = ctrl.valid[OUT];
    assign o_red_out   = r_red;
    assign o_green_out = r_green;
    assign o_blue_out  = r_blue;

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

    a_in_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without a stalled output");

endmodule

`default_nettype wire

>>> tb/rgpe_checker.sv
// rgpe_checker: watches the pixel, result and gain channels of the tone map encoder,
// predicts the three output bytes of every accepted pixel and compares them in order
// depends on rgpe_pkg for widths and the fraction bit count
`timescale 1ns / 1ps

module rgpe_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_ready,
    input  wire logic [rgpe_pkg::CH_W-1:0]     i_red_in,
    input  wire logic [rgpe_pkg::CH_W-1:0]     i_green_in,
    input  wire logic [rgpe_pkg::CH_W-1:0]     i_blue_in,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic [rgpe_pkg::BYTE_W-1:0]   i_red_out,
    input  wire logic [rgpe_pkg::BYTE_W-1:0]   i_green_out,
    input  wire logic [rgpe_pkg::BYTE_W-1:0]   i_blue_out,
    input  wire logic                          i_cfg_valid,
    input  wire logic                          i_cfg_ready,
    input  wire logic [rgpe_pkg::GAIN_W-1:0]   i_cfg_data,
    output int                                 o_errors,
    output int                                 o_pending
);

    localparam int          CH_W       = rgpe_pkg::CH_W;
    localparam int          GAIN_W     = rgpe_pkg::GAIN_W;
    localparam int          BYTE_W     = rgpe_pkg::BYTE_W;
    localparam int          NUM_LEVELS = rgpe_pkg::NUM_LEVELS;
    localparam int          WIDE       = 384;
    localparam int          FRAC       = rgpe_pkg::FRACTION_BITS;
    localparam int          SHOWN      = 10;
    localparam int          DEPTH      = 64;
    localparam logic [63:0] MAX_X      = 64'h7FFF_FFFF;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } t_pixel_bytes;

    logic [WIDE-1:0]   level_pow [NUM_LEVELS];
    logic [WIDE-1:0]   scale_pow;
    logic [GAIN_W-1:0] gain_copy;
    t_pixel_bytes      expected_pixels [DEPTH];
    int                head = 0;
    int                tail = 0;
    int                error_count = 0;

    assign o_errors  = error_count;
    assign o_pending = tail - head;

    initial begin : build_powers
        logic [WIDE-1:0] acc;
        scale_pow = WIDE'(1);
        for (int i = 0; i < 11; i++) begin
            scale_pow = scale_pow * WIDE'(255999);
        end
        for (int k = 0; k < NUM_LEVELS; k++) begin
            acc = WIDE'(1);
            for (int i = 0; i < 11; i++) begin
                acc = acc * WIDE'(1000 * k);
            end
            level_pow[k] = acc;
        end
    end

    // largest level k with (1000k)^11 * (2^F + x)^5 <= x^5 * 255999^11
    function automatic logic [BYTE_W-1:0] encode_level(input logic [CH_W-1:0] radiance,
                                                       input logic [GAIN_W-1:0] gain);
        logic [63:0]     scaled;
        logic [WIDE-1:0] x_w;
        logic [WIDE-1:0] x_pow;
        logic [WIDE-1:0] den_pow;
        logic [WIDE-1:0] rhs;
        int              lo;
        int              hi;
        int              mid;
        if (radiance[CH_W-1] || radiance == '0) begin
            return '0;
        end
        scaled = (64'(radiance) * 64'(gain)) >> FRAC;
        if (scaled > MAX_X) begin
            scaled = MAX_X;
        end
        if (scaled == 64'd0) begin
            return '0;
        end
        x_w     = WIDE'(scaled);
        x_pow   = WIDE'(1);
        den_pow = WIDE'(1);
        for (int i = 0; i < 5; i++) begin
            x_pow   = x_pow * x_w;
            den_pow = den_pow * (x_w + (WIDE'(1) << FRAC));
        end
        rhs = x_pow * scale_pow;
        lo  = 0;
        hi  = NUM_LEVELS - 1;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (level_pow[mid] * den_pow <= rhs) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return BYTE_W'(lo);
    endfunction

    always @(posedge i_clk) begin : watch
        t_pixel_bytes want;
        t_pixel_bytes got;
        if (!i_rst_n) begin
            gain_copy = GAIN_W'(1) << FRAC;
            head      = 0;
            tail      = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.red   = i_red_out;
                got.green = i_green_out;
                got.blue  = i_blue_out;
                if (tail == head) begin
                    if (error_count < SHOWN) begin
                        $display("%0t unexpected pixel r=%0d g=%0d b=%0d",
                                 $time, got.red, got.green, got.blue);
                    end
                    error_count++;
                end else begin
                    want = expected_pixels[head % DEPTH];
                    head++;
                    if (want.red != got.red || want.green != got.green
                            || want.blue != got.blue) begin
                        if (error_count < SHOWN) begin
                            $display("%0t mismatch: expected r=%0d g=%0d b=%0d,",
                                     $time, want.red, want.green, want.blue);
                            $display("    got r=%0d g=%0d b=%0d",
                                     got.red, got.green, got.blue);
                        end
                        error_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                want.red   = encode_level(i_red_in, gain_copy);
                want.green = encode_level(i_green_in, gain_copy);
                want.blue  = encode_level(i_blue_in, gain_copy);
                if (tail - head >= DEPTH) begin
                    if (error_count < SHOWN) begin
                        $display("%0t too many pixels in flight", $time);
                    end
                    error_count++;
                end else begin
                    expected_pixels[tail % DEPTH] = want;
                    tail++;
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                gain_copy = i_cfg_data;
            end
        end
    end

endmodule

>>> tb/tb_reinhard_gamma_pixel_encoder.sv
// tb_reinhard_gamma_pixel_encoder: drives pixels and exposure gain writes into the
// encoder with random idling on both sides and gives the verdict
// depends on rgpe_pkg, rgpe_checker and reinhard_gamma_pixel_encoder
`timescale 1ns / 1ps

module tb_reinhard_gamma_pixel_encoder;

    localparam int CH_W         = rgpe_pkg::CH_W;
    localparam int BYTE_W       = rgpe_pkg::BYTE_W;
    localparam int GAIN_W       = rgpe_pkg::GAIN_W;
    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 7;
    localparam int LATENCY      = 11;
    localparam int IDLE_LIMIT   = 4000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 160;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_FIRST   = 150;
    localparam int HOLD_SECOND  = 900;
    localparam int TX_SIDE      = 0;
    localparam int RX_SIDE      = 1;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [CH_W-1:0]   red_in;
    logic [CH_W-1:0]   green_in;
    logic [CH_W-1:0]   blue_in;
    logic              out_valid;
    logic              out_ready;
    logic [BYTE_W-1:0] red_out;
    logic [BYTE_W-1:0] green_out;
    logic [BYTE_W-1:0] blue_out;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [GAIN_W-1:0] cfg_data;
    int                errors;
    int                pending;
    int                idle_cycles = 0;
    int                tx_calm = 0;
    int                rx_calm = 0;

    always begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    reinhard_gamma_pixel_encoder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_red_in    (red_in),
        .i_green_in  (green_in),
        .i_blue_in   (blue_in),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_red_out   (red_out),
        .o_green_out (green_out),
        .o_blue_out  (blue_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    rgpe_checker u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_red_in    (red_in),
        .i_green_in  (green_in),
        .i_blue_in   (blue_in),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_red_out   (red_out),
        .i_green_out (green_out),
        .i_blue_out  (blue_out),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // mostly short gaps, a few long ones, and calm stretches with none
    function automatic int next_gap(input int side);
        int calm;
        int pick;
        int gap;
        calm = (side == TX_SIDE) ? tx_calm : rx_calm;
        if (calm > 0) begin
            calm--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 39) == 0) begin
                calm = $urandom_range(20, 80);
            end
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                gap = 0;
            end else if (pick < 88) begin
                gap = $urandom_range(1, 3);
            end else if (pick < 97) begin
                gap = $urandom_range(4, 12);
            end else begin
                gap = $urandom_range(20, 60);
            end
        end
        if (side == TX_SIDE) begin
            tx_calm = calm;
        end else begin
            rx_calm = calm;
        end
        return gap;
    endfunction

    function automatic logic [CH_W-1:0] rand_radiance();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            return '0;
        end else if (pick < 20) begin
            return {1'b1, 31'($urandom)};
        end else if (pick < 30) begin
            return CH_W'($urandom);
        end else if (pick < 38) begin
            case ($urandom_range(0, 3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0000_0001;
            endcase
        end
        return CH_W'($urandom >> $urandom_range(1, 31));
    endfunction

    function automatic logic [GAIN_W-1:0] phase_gain(input int phase);
        case (phase)
            0: return 32'h0001_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0000_0001;
            3: return GAIN_W'($urandom);
            4: return GAIN_W'($urandom >> $urandom_range(8, 24));
            5: return 32'h0000_0000;
            6: return 32'h0002_8000;
            default: return GAIN_W'($urandom >> $urandom_range(0, 16));
        endcase
    endfunction

    task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                              input logic [CH_W-1:0] b);
        int gap;
        gap = next_gap(TX_SIDE);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_gain(input logic [GAIN_W-1:0] gain);
        cfg_valid <= 1'b1;
        cfg_data  <= gain;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)
                    || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : receiver
        int gap;
        int taken;
        taken     = 0;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        @(negedge clk);
        forever begin
            gap = next_gap(RX_SIDE);
            // long hold so the pipeline fills and input stalls
            if (taken == HOLD_FIRST || taken == HOLD_SECOND) begin
                gap = LONG_HOLD;
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            taken++;
            @(negedge clk);
        end
    end

    initial begin : stimulus
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        red_in    = '0;
        green_in  = '0;
        blue_in   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset gain of 1.0
        send_pixel(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_pixel(32'h0000_0001, 32'h0000_0002, 32'h0000_0003);
        send_pixel(32'h0001_0000, 32'h0000_8000, 32'h0002_0000);
        send_pixel(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_pixel(32'h0073_0000, 32'h0074_0000, 32'h00FF_0000);
        send_pixel(32'hFFFF_0000, 32'h0000_0100, 32'h0000_0010);
        send_pixel(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
        send_pixel(32'h0000_000A, 32'h0000_0040, 32'h0000_1000);
        drain();

        // zero gain
        write_gain(32'h0000_0000);
        send_pixel(32'h7FFF_FFFF, 32'h0001_0000, 32'h0000_0001);
        send_pixel(32'h8000_0000, 32'h00FF_FFFF, 32'h0000_8000);
        drain();

        // largest gain, products saturate
        write_gain(32'hFFFF_FFFF);
        send_pixel(32'h7FFF_FFFF, 32'h0001_0000, 32'h0000_8000);
        send_pixel(32'h0000_0001, 32'h0000_FFFF, 32'h8000_0001);
        send_pixel(32'h0000_0002, 32'h4000_0000, 32'h0000_0000);
        drain();

        // smallest nonzero gain, small products truncate to zero
        write_gain(32'h0000_0001);
        send_pixel(32'h7FFF_FFFF, 32'h0001_0000, 32'h0000_FFFF);
        send_pixel(32'h0002_0000, 32'h0100_0000, 32'h8000_0000);
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            write_gain(phase_gain(phase));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_pixel(rand_radiance(), rand_radiance(), rand_radiance());
            end
            drain();
        end

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> reinhard_gamma_pixel_encoder.f
design/rgpe_pkg.sv
design/rgpe_ctrl.sv
design/rgpe_lane.sv
design/reinhard_gamma_pixel_encoder.sv
tb/rgpe_checker.sv
tb/tb_reinhard_gamma_pixel_encoder.sv
